/* hdl/sprt_pkg.sv */
// Shared types and constants for the sprite pixel rotate/tint block.
// Used by sprt_coord, sprt_colour and the top level sprite_pixel_rotate_tint.
package sprt_pkg;

    localparam int SURFACE_WIDTH_DEF  = 1024;
    localparam int SURFACE_HEIGHT_DEF = 1024;

    localparam int COLOUR_W = 24;
    localparam int OFFSET_W = 10;
    localparam int COORD_W  = 10;
    localparam int BRIGHT_W = 10;
    localparam int KEY_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Intermediate coordinate width: signed 16-bit origin plus up to 2*32767 plus 1023.
    localparam int POS_W = 19;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ODD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOURTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACEMENT  = 3'd7;

    // Quarter-turn codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // A colour register holding -1 is switched off
    localparam logic [KEY_W-1:0] COLOUR_OFF = '1;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 10'd100;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] origin_y;
        logic [15:0] origin_x;
    } t_place_cfg;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    odd;
        logic [KEY_W-1:0]    third;
        logic [KEY_W-1:0]    fourth;
        logic [KEY_W-1:0]    blend;
    } t_colour_cfg;

endpackage

/* hdl/sprt_coord.sv */
// Target coordinate path: quarter-turn mapping, edge wrap, alignment stage.
// Depends on sprt_pkg.
module sprt_coord import sprt_pkg::*; #(
    parameter int SURFACE_WIDTH  = SURFACE_WIDTH_DEF,
    parameter int SURFACE_HEIGHT = SURFACE_HEIGHT_DEF
) (
    input  logic                i_clk,
    input  t_place_cfg          i_cfg,
    input  logic [OFFSET_W-1:0] i_column_offset,
    input  logic [OFFSET_W-1:0] i_row_offset,
    output logic [COORD_W-1:0]  o_dest_x,
    output logic [COORD_W-1:0]  o_dest_y
);

    localparam logic signed [POS_W-1:0] SW = POS_W'(SURFACE_WIDTH);
    localparam logic signed [POS_W-1:0] SH = POS_W'(SURFACE_HEIGHT);
    localparam logic [COORD_W-1:0] SW_LAST = COORD_W'(SURFACE_WIDTH - 1);
    localparam logic [COORD_W-1:0] SH_LAST = COORD_W'(SURFACE_HEIGHT - 1);

    logic signed [POS_W-1:0] n_pos_x, n_pos_y, r_pos_x, r_pos_y;
    logic [COORD_W-1:0] n_wrap_x, n_wrap_y, r_wrap_x, r_wrap_y;
    logic [COORD_W-1:0] r_out_x, r_out_y;

    logic signed [POS_W-1:0] org_x, org_y, even_w, even_h, col_s, row_s;
    logic signed [POS_W-1:0] off_x, off_y, step_x, step_y;

    // Stage 1: origin plus rotated offsets
    always_comb begin
        org_x  = {{(POS_W-16){i_cfg.origin_x[15]}}, i_cfg.origin_x};
        org_y  = {{(POS_W-16){i_cfg.origin_y[15]}}, i_cfg.origin_y};
        even_w = {{(POS_W-16){1'b0}}, i_cfg.width[15:1], 1'b0};
        even_h = {{(POS_W-16){1'b0}}, i_cfg.height[15:1], 1'b0};
        col_s  = {{(POS_W-OFFSET_W){1'b0}}, i_column_offset};
        row_s  = {{(POS_W-OFFSET_W){1'b0}}, i_row_offset};
        case (i_cfg.rotation)
            ROT_0: begin
                off_x = '0;     off_y = '0;
                step_x = col_s; step_y = row_s;
            end
            ROT_90: begin
                off_x = even_w; off_y = '0;
                step_x = -row_s; step_y = col_s;
            end
            ROT_180: begin
                off_x = even_w; off_y = even_h;
                step_x = -col_s; step_y = -row_s;
            end
            default: begin
                off_x = '0;     off_y = even_h;
                step_x = row_s; step_y = -col_s;
            end
        endcase
        n_pos_x = org_x + off_x + step_x;
        n_pos_y = org_y + off_y + step_y;
    end

    // Stage 2: single-step wrap at the surface edges
    always_comb begin
        if (r_pos_x < 0) begin
            n_wrap_x = SW_LAST;
        end else if (r_pos_x >= SW) begin
            n_wrap_x = '0;
        end else begin
            n_wrap_x = r_pos_x[COORD_W-1:0];
        end
        if (r_pos_y < 0) begin
            n_wrap_y = SH_LAST;
        end else if (r_pos_y >= SH) begin
            n_wrap_y = '0;
        end else begin
            n_wrap_y = r_pos_y[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_wrap_x <= n_wrap_x;
        r_wrap_y <= n_wrap_y;
        // Stage 3: hold in step with the colour path
        r_out_x  <= r_wrap_x;
        r_out_y  <= r_wrap_y;
    end

    assign o_dest_x = r_out_x;
    assign o_dest_y = r_out_y;

endmodule

/* hdl/sprt_colour.sv */
// Colour path: key test, phase patterns, brightness scale, merge, clamp and rounding.
// Depends on sprt_pkg.
module sprt_colour import sprt_pkg::*; (
    input  logic                i_clk,
    input  t_colour_cfg         i_cfg,
    input  logic [COLOUR_W-1:0] i_source_colour,
    input  logic [OFFSET_W-1:0] i_column_offset,
    input  logic [OFFSET_W-1:0] i_row_offset,
    output logic                o_write_enable,
    output logic [COLOUR_W-1:0] o_dest_colour
);

    // (n + 100) / 200 == ((n + 100) >> 3) / 25, and t / 25 == (t * 10486) >> 18 for t < 43690
    localparam logic [13:0] RECIP_25 = 14'd10486;
    localparam logic [18:0] CLAMP_N  = 19'd51000;
    localparam logic [18:0] ROUND_N  = 19'd100;

    function automatic logic [1:0] mod3(input logic [OFFSET_W:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        // base-4 digits sum to the same residue
        s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[10]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    endfunction

    // Stage 1 registers
    logic                r1_key_hit;
    logic [OFFSET_W:0]   r1_phase;
    logic [2:0][17:0]    r1_prod;

    // Stage 2 registers
    logic                r2_key_hit;
    logic                r2_set;
    logic [COLOUR_W-1:0] r2_pattern;
    logic [2:0][12:0]    r2_quot_in;
    logic [2:0]          r2_clamp;

    // Stage 3 registers
    logic                r3_write_enable;
    logic [COLOUR_W-1:0] r3_colour;

    logic [OFFSET_W:0]   n1_phase;
    logic [2:0][17:0]    n1_prod;
    logic                n1_key_hit;

    logic                odd_hit, third_hit, fourth_hit, merge;
    logic                n2_set;
    logic [COLOUR_W-1:0] n2_pattern;
    logic [2:0][18:0]    n2_num;
    logic [2:0][18:0]    n2_round;
    logic [2:0][12:0]    n2_quot_in;
    logic [2:0]          n2_clamp;

    logic [2:0][26:0]    n3_prod;
    logic [2:0][7:0]     n3_chan;
    logic [COLOUR_W-1:0] n3_colour;

    // Stage 1: key compare, phase, per-channel scale
    always_comb begin
        n1_key_hit = !i_cfg.key[KEY_W-1] && (i_cfg.key[COLOUR_W-1:0] == i_source_colour);
        n1_phase   = (OFFSET_W+1)'(i_column_offset) + (OFFSET_W+1)'(i_row_offset);
        for (int c = 0; c < 3; c++) begin
            n1_prod[c] = 18'(i_source_colour[8*c +: 8]) * 18'(i_cfg.brightness);
        end
    end

    // Stage 2: pattern pick, merge, clamp test, first half of the divide by 200
    always_comb begin
        odd_hit    = (i_cfg.odd    != COLOUR_OFF) && r1_phase[0];
        third_hit  = (i_cfg.third  != COLOUR_OFF) && (mod3(r1_phase) == 2'd1);
        fourth_hit = (i_cfg.fourth != COLOUR_OFF) && (r1_phase[1:0] == 2'd1);
        merge      = (i_cfg.blend  != COLOUR_OFF);
        n2_set     = odd_hit || third_hit || fourth_hit;
        // later pattern wins
        if (fourth_hit) begin
            n2_pattern = i_cfg.fourth[COLOUR_W-1:0];
        end else if (third_hit) begin
            n2_pattern = i_cfg.third[COLOUR_W-1:0];
        end else begin
            n2_pattern = i_cfg.odd[COLOUR_W-1:0];
        end
        for (int c = 0; c < 3; c++) begin
            // without merge, 2p over 200 gives the same result as p over 100
            n2_num[c] = merge ? (19'(r1_prod[c]) + 19'(i_cfg.blend[8*c +: 8]) * 19'd100)
                              : {r1_prod[c], 1'b0};
            n2_clamp[c]   = n2_num[c] > CLAMP_N;
            n2_round[c]   = n2_num[c] + ROUND_N;
            n2_quot_in[c] = n2_round[c][15:3];
        end
    end

    // Stage 3: divide by 25 through the reciprocal, assemble the colour
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n3_prod[c] = 27'(r2_quot_in[c]) * 27'(RECIP_25);
            n3_chan[c] = r2_clamp[c] ? 8'hFF : n3_prod[c][25:18];
        end
        if (r2_key_hit) begin
            n3_colour = '0;
        end else if (r2_set) begin
            n3_colour = r2_pattern;
        end else begin
            n3_colour = {n3_chan[2], n3_chan[1], n3_chan[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_key_hit      <= n1_key_hit;
        r1_phase        <= n1_phase;
        r1_prod         <= n1_prod;
        r2_key_hit      <= r1_key_hit;
        r2_set          <= n2_set;
        r2_pattern      <= n2_pattern;
        r2_quot_in      <= n2_quot_in;
        r2_clamp        <= n2_clamp;
        r3_write_enable <= !r2_key_hit;
        r3_colour       <= n3_colour;
    end

    assign o_write_enable = r3_write_enable;
    assign o_dest_colour  = r3_colour;

endmodule

/* hdl/sprite_pixel_rotate_tint.sv */
// A transfer passes the stage valid bits on to the o_done strobe; one pixel per clock.
// Throughput is set by the three-stage pipeline, which never stalls: o_busy stays low.
// Results show for one cycle only; the receiver cannot stall.
// Reset (synchronous, active low) clears the stage valid bits and loads the register
// defaults: rotation 0, brightness 100, all colours off (-1), placement 0.
module sprite_pixel_rotate_tint import sprt_pkg::*; #(
    parameter int SURFACE_WIDTH  = SURFACE_WIDTH_DEF,
    parameter int SURFACE_HEIGHT = SURFACE_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel command
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [COLOUR_W-1:0]   i_source_colour,
    input  logic [OFFSET_W-1:0]   i_column_offset,
    input  logic [OFFSET_W-1:0]   i_row_offset,
    // result
    output logic                  o_done,
    output logic                  o_write_enable,
    output logic [COORD_W-1:0]    o_dest_x,
    output logic [COORD_W-1:0]    o_dest_y,
    output logic [COLOUR_W-1:0]   o_dest_colour,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [1:0]          r_rotation,   n_rotation;
    logic [BRIGHT_W-1:0] r_brightness, n_brightness;
    logic [KEY_W-1:0]    r_key,        n_key;
    logic [KEY_W-1:0]    r_odd,        n_odd;
    logic [KEY_W-1:0]    r_third,      n_third;
    logic [KEY_W-1:0]    r_fourth,     n_fourth;
    logic [KEY_W-1:0]    r_blend,      n_blend;
    logic [63:0]         r_placement,  n_placement;

    // Valid bit per pipeline stage
    logic [2:0] r_vld, n_vld;

    t_place_cfg  place_cfg;
    t_colour_cfg colour_cfg;

    logic [COORD_W-1:0] coord_x, coord_y;
    logic               pix_we;

    // The pipeline advances every cycle, so both sides are always open
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Register write decode; unknown indexes drop through
    always_comb begin
        n_rotation   = r_rotation;
        n_brightness = r_brightness;
        n_key        = r_key;
        n_odd        = r_odd;
        n_third      = r_third;
        n_fourth     = r_fourth;
        n_blend      = r_blend;
        n_placement  = r_placement;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROTATION:   n_rotation   = i_cfg_data[1:0];
                CFG_BRIGHTNESS: n_brightness = i_cfg_data[BRIGHT_W-1:0];
                CFG_KEY:        n_key        = i_cfg_data[KEY_W-1:0];
                CFG_ODD:        n_odd        = i_cfg_data[KEY_W-1:0];
                CFG_THIRD:      n_third      = i_cfg_data[KEY_W-1:0];
                CFG_FOURTH:     n_fourth     = i_cfg_data[KEY_W-1:0];
                CFG_BLEND:      n_blend      = i_cfg_data[KEY_W-1:0];
                CFG_PLACEMENT:  n_placement  = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance the valid bits with the data; a transfer enters stage one
    assign n_vld = {r_vld[1:0], i_start && !o_busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation   <= ROT_0;
            r_brightness <= BRIGHT_RESET;
            r_key        <= COLOUR_OFF;
            r_odd        <= COLOUR_OFF;
            r_third      <= COLOUR_OFF;
            r_fourth     <= COLOUR_OFF;
            r_blend      <= COLOUR_OFF;
            r_placement  <= '0;
            r_vld        <= '0;
        end else begin
            r_rotation   <= n_rotation;
            r_brightness <= n_brightness;
            r_key        <= n_key;
            r_odd        <= n_odd;
            r_third      <= n_third;
            r_fourth     <= n_fourth;
            r_blend      <= n_blend;
            r_placement  <= n_placement;
            r_vld        <= n_vld;
        end
    end

    // Keep configuration stable while pixels are in flight (not enforced); read live
    always_comb begin
        place_cfg.rotation  = r_rotation;
        place_cfg.origin_x  = r_placement[15:0];
        place_cfg.origin_y  = r_placement[31:16];
        place_cfg.width     = r_placement[47:32];
        place_cfg.height    = r_placement[63:48];
        colour_cfg.brightness = r_brightness;
        colour_cfg.key        = r_key;
        colour_cfg.odd        = r_odd;
        colour_cfg.third      = r_third;
        colour_cfg.fourth     = r_fourth;
        colour_cfg.blend      = r_blend;
    end

    sprt_coord #(
        .SURFACE_WIDTH  (SURFACE_WIDTH),
        .SURFACE_HEIGHT (SURFACE_HEIGHT)
    ) u_coord (
        .i_clk           (i_clk),
        .i_cfg           (place_cfg),
        .i_column_offset (i_column_offset),
        .i_row_offset    (i_row_offset),
        .o_dest_x        (coord_x),
        .o_dest_y        (coord_y)
    );

    sprt_colour u_colour (
        .i_clk           (i_clk),
        .i_cfg           (colour_cfg),
        .i_source_colour (i_source_colour),
        .i_column_offset (i_column_offset),
        .i_row_offset    (i_row_offset),
        .o_write_enable  (pix_we),
        .o_dest_colour   (o_dest_colour)
    );

    // A keyed pixel reports zero coordinates
    assign o_done         = r_vld[2];
    assign o_write_enable = pix_we;
    assign o_dest_x       = pix_we ? coord_x : '0;
    assign o_dest_y       = pix_we ? coord_y : '0;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_done)
        else $error("pixel transfer did not complete after three cycles");

    a_keyed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_write_enable) |->
        (o_dest_x == '0 && o_dest_y == '0 && o_dest_colour == '0))
        else $error("keyed pixel carries nonzero result fields");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");
`endif

endmodule

/* bench/sprite_pixel_rotate_tint_check.sv */
// Checker for the sprite pixel rotate/tint block: predicts every pixel write from the
// accepted commands and register writes, and compares the o_done results in order.
// Depends on sprt_pkg for widths, register indexes, quarter-turn codes and COLOUR_OFF.
module sprite_pixel_rotate_tint_check import sprt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [COLOUR_W-1:0]   i_source_colour,
    input  logic [OFFSET_W-1:0]   i_column_offset,
    input  logic [OFFSET_W-1:0]   i_row_offset,
    input  logic                  i_done,
    input  logic                  i_write_enable,
    input  logic [COORD_W-1:0]    i_dest_x,
    input  logic [COORD_W-1:0]    i_dest_y,
    input  logic [COLOUR_W-1:0]   i_dest_colour,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_error_count,
    output int                    o_pending
);

    typedef struct packed {
        logic                we;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOUR_W-1:0] rgb;
    } t_pixel_write;

    // Register copies
    logic [1:0]            turns_q;
    logic [BRIGHT_W-1:0]   bright_pct;
    logic [KEY_W-1:0]      key_rgb;
    logic [KEY_W-1:0]      odd_rgb;
    logic [KEY_W-1:0]      third_rgb;
    logic [KEY_W-1:0]      fourth_rgb;
    logic [KEY_W-1:0]      blend_rgb;
    logic [CFG_DATA_W-1:0] place_cfg;

    t_pixel_write pending_writes[$];
    int           mismatch_total = 0;

    function automatic logic [7:0] tint_chan(input logic [7:0] c, input bit merge,
                                             input logic [7:0] m);
        int unsigned scaled;
        int unsigned sum;
        scaled = 32'(c) * 32'(bright_pct);
        if (merge) begin
            sum = scaled + 32'(m) * 100;
            if (sum > 51000) return 8'd255;
            return 8'((sum + 100) / 200);
        end
        if (scaled > 25500) return 8'd255;
        return 8'((scaled + 50) / 100);
    endfunction

    function automatic t_pixel_write blit_pixel(input logic [COLOUR_W-1:0] src,
                                                input logic [OFFSET_W-1:0] col,
                                                input logic [OFFSET_W-1:0] row);
        t_pixel_write res;
        longint ox, oy, wd, ht, px, py, c, r;
        int unsigned phase;
        bit painted;
        logic [COLOUR_W-1:0] rgb;
        res = '0;
        // keyed pixel: nothing written, all result fields zero
        if (!key_rgb[KEY_W-1] && key_rgb[COLOUR_W-1:0] == src) return res;

        ox = longint'($signed(place_cfg[15:0]));
        oy = longint'($signed(place_cfg[31:16]));
        wd = longint'(place_cfg[47:32]);
        ht = longint'(place_cfg[63:48]);
        c  = longint'(col);
        r  = longint'(row);
        // mirrored axes start at the far edge, which is side-1 for an odd side
        case (turns_q)
            ROT_0: begin
                px = ox + c;
                py = oy + r;
            end
            ROT_90: begin
                px = ox + 2 * (wd / 2) - r;
                py = oy + c;
            end
            ROT_180: begin
                px = ox + 2 * (wd / 2) - c;
                py = oy + 2 * (ht / 2) - r;
            end
            ROT_270: begin
                px = ox + r;
                py = oy + 2 * (ht / 2) - c;
            end
        endcase
        if (px < 0) px = SURFACE_WIDTH_DEF - 1;
        if (px >= SURFACE_WIDTH_DEF) px = 0;
        if (py < 0) py = SURFACE_HEIGHT_DEF - 1;
        if (py >= SURFACE_HEIGHT_DEF) py = 0;

        phase   = 32'(col) + 32'(row);
        painted = 1'b0;
        rgb     = src;
        if (odd_rgb != COLOUR_OFF && phase % 2 == 1) begin
            rgb = odd_rgb[COLOUR_W-1:0];
            painted = 1'b1;
        end
        if (third_rgb != COLOUR_OFF && phase % 3 == 1) begin
            rgb = third_rgb[COLOUR_W-1:0];
            painted = 1'b1;
        end
        if (fourth_rgb != COLOUR_OFF && phase % 4 == 1) begin
            rgb = fourth_rgb[COLOUR_W-1:0];
            painted = 1'b1;
        end
        if (!painted) begin
            rgb = {tint_chan(src[23:16], blend_rgb != COLOUR_OFF, blend_rgb[23:16]),
                   tint_chan(src[15:8],  blend_rgb != COLOUR_OFF, blend_rgb[15:8]),
                   tint_chan(src[7:0],   blend_rgb != COLOUR_OFF, blend_rgb[7:0])};
        end

        res.we  = 1'b1;
        res.x   = px[COORD_W-1:0];
        res.y   = py[COORD_W-1:0];
        res.rgb = rgb;
        return res;
    endfunction

    // Report and count a field mismatch
    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_write want;
        if (!i_rst_n) begin
            turns_q    = ROT_0;
            bright_pct = BRIGHT_RESET;
            key_rgb    = COLOUR_OFF;
            odd_rgb    = COLOUR_OFF;
            third_rgb  = COLOUR_OFF;
            fourth_rgb = COLOUR_OFF;
            blend_rgb  = COLOUR_OFF;
            place_cfg  = '0;
            pending_writes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROTATION:   turns_q    = i_cfg_data[1:0];
                    CFG_BRIGHTNESS: bright_pct = i_cfg_data[BRIGHT_W-1:0];
                    CFG_KEY:        key_rgb    = i_cfg_data[KEY_W-1:0];
                    CFG_ODD:        odd_rgb    = i_cfg_data[KEY_W-1:0];
                    CFG_THIRD:      third_rgb  = i_cfg_data[KEY_W-1:0];
                    CFG_FOURTH:     fourth_rgb = i_cfg_data[KEY_W-1:0];
                    CFG_BLEND:      blend_rgb  = i_cfg_data[KEY_W-1:0];
                    CFG_PLACEMENT:  place_cfg  = i_cfg_data;
                endcase
            end
            if (i_start && !i_busy)
                pending_writes.push_back(blit_pixel(i_source_colour, i_column_offset,
                                                    i_row_offset));
            if (i_done) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing actual 0x%0h",
                             $time, {i_write_enable, i_dest_x, i_dest_y, i_dest_colour});
                    mismatch_total++;
                end else begin
                    want = pending_writes.pop_front();
                    check_field("write_enable", 24'(want.we), 24'(i_write_enable));
                    check_field("dest_x", 24'(want.x), 24'(i_dest_x));
                    check_field("dest_y", 24'(want.y), 24'(i_dest_y));
                    check_field("dest_colour", want.rgb, i_dest_colour);
                end
            end
        end
        o_pending     <= pending_writes.size();
        o_error_count <= mismatch_total;
    end

endmodule

/* bench/sprite_pixel_rotate_tint_test.sv */
// Top of the sprite pixel rotate/tint bench: clock, reset, register writes and pixel commands.
// Depends on sprt_pkg, the block sprite_pixel_rotate_tint and sprite_pixel_rotate_tint_check.
module sprite_pixel_rotate_tint_test import sprt_pkg::*;;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [COLOUR_W-1:0]   i_source_colour;
    logic [OFFSET_W-1:0]   i_column_offset;
    logic [OFFSET_W-1:0]   i_row_offset;
    logic                  o_done;
    logic                  o_write_enable;
    logic [COORD_W-1:0]    o_dest_x;
    logic [COORD_W-1:0]    o_dest_y;
    logic [COLOUR_W-1:0]   o_dest_colour;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int error_total;
    int writes_owed;
    int cycles = 0;

    // No-gap stretch flag for the command side
    bit burst = 1'b0;
    // Key last written, so random pixels can hit it now and then
    logic [KEY_W-1:0] key_now = COLOUR_OFF;

    sprite_pixel_rotate_tint dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_source_colour (i_source_colour),
        .i_column_offset (i_column_offset),
        .i_row_offset    (i_row_offset),
        .o_done          (o_done),
        .o_write_enable  (o_write_enable),
        .o_dest_x        (o_dest_x),
        .o_dest_y        (o_dest_y),
        .o_dest_colour   (o_dest_colour),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    sprite_pixel_rotate_tint_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_source_colour (i_source_colour),
        .i_column_offset (i_column_offset),
        .i_row_offset    (i_row_offset),
        .i_done          (o_done),
        .i_write_enable  (o_write_enable),
        .i_dest_x        (o_dest_x),
        .i_dest_y        (o_dest_y),
        .i_dest_colour   (o_dest_colour),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_total),
        .o_pending       (writes_owed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one register write and hold valid until the transfer; the caller drops
    // valid after the last write of a batch.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Load every register; the block must be idle
    task automatic write_all(input logic [1:0] rot, input logic [BRIGHT_W-1:0] pct,
                             input logic [63:0] key, input logic [63:0] odd,
                             input logic [63:0] third, input logic [63:0] fourth,
                             input logic [63:0] blend, input logic [63:0] place);
        logic [63:0] junk;
        // fill unused upper bits with noise so truncation is exercised
        junk = {$urandom, $urandom};
        cfg_write(CFG_ROTATION, {junk[63:2], rot});
        cfg_write(CFG_BRIGHTNESS, {junk[63:BRIGHT_W], pct});
        cfg_write(CFG_KEY, key);
        cfg_write(CFG_ODD, odd);
        cfg_write(CFG_THIRD, third);
        cfg_write(CFG_FOURTH, fourth);
        cfg_write(CFG_BLEND, blend);
        cfg_write(CFG_PLACEMENT, place);
        i_cfg_valid <= 1'b0;
        key_now = key[KEY_W-1:0];
    endtask

    // Issue one pixel command after a random idle gap (none inside a burst)
    task automatic send_pixel(input logic [COLOUR_W-1:0] src, input logic [OFFSET_W-1:0] col,
                              input logic [OFFSET_W-1:0] row);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_source_colour <= src;
        i_column_offset <= col;
        i_row_offset    <= row;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Hold until every predicted write has come back; start must already be low
    task automatic wait_drained();
        do @(posedge i_clk); while (writes_owed != 0);
    endtask

    // Colour register value: off, a plain colour, or a negative word that still enables
    function automatic logic [63:0] colour_setting();
        logic [63:0] word;
        word = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0, 1:    word[KEY_W-1:0] = COLOUR_OFF;
            2, 3:    word[KEY_W-1:0] = {1'b0, 24'($urandom)};
            default: word[KEY_W-1:0] = {1'b1, 24'($urandom)};
        endcase
        return word;
    endfunction

    // Placement: mostly near the surface with small sides, sometimes anything at all
    function automatic logic [63:0] placement_setting();
        int ox, oy, wd, ht;
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        ox = int'($urandom_range(0, 1200)) - 100;
        oy = int'($urandom_range(0, 1200)) - 100;
        wd = $urandom_range(0, 70);
        ht = $urandom_range(0, 70);
        return {16'(ht), 16'(wd), 16'(oy), 16'(ox)};
    endfunction

    function automatic logic [BRIGHT_W-1:0] brightness_setting();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return BRIGHT_RESET;
            default: return BRIGHT_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [COLOUR_W-1:0] src;
        // drive every input to a known value before the first edge
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_source_colour = '0;
        i_column_offset = '0;
        i_row_offset    = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: identity placement, unity brightness, corners of the offsets
        send_pixel(24'h000000, 10'd0, 10'd0);
        send_pixel(24'hFFFFFF, 10'd1023, 10'd1023);
        send_pixel(24'hFFFFFF, 10'd1023, 10'd0);
        send_pixel(24'h808080, 10'd0, 10'd1023);
        send_pixel(24'h123456, 10'd5, 10'd7);
        i_start <= 1'b0;
        wait_drained();

        // Quarter turn with all three patterns on, a key, full brightness and wrap below zero
        write_all(ROT_90, 10'd1023, 64'h00FF00, 64'h111111, 64'h222222, 64'h333333,
                  64'(COLOUR_OFF), {16'd9, 16'd7, 16'hFFFB, 16'd10});
        send_pixel(24'h00FF00, 10'd3, 10'd4);      // keyed, no write
        send_pixel(24'h0A0B0C, 10'd0, 10'd0);      // no pattern, scaled
        send_pixel(24'h0A0B0C, 10'd0, 10'd1);      // all three match, last one wins
        send_pixel(24'h0A0B0C, 10'd1, 10'd2);      // odd only
        send_pixel(24'h0A0B0C, 10'd2, 10'd2);      // third only
        send_pixel(24'h0A0B0C, 10'd5, 10'd0);      // odd and fourth
        send_pixel(24'hFFFFFF, 10'd1023, 10'd1023); // scale clamps
        i_start <= 1'b0;
        wait_drained();

        // Half turn at the placement extremes, negative key that never matches,
        // negative odd colour that still counts, merge at zero brightness
        write_all(ROT_180, 10'd0, 64'h1_00ABCD, 64'h1_445566, 64'(COLOUR_OFF),
                  64'(COLOUR_OFF), 64'h00FF80, {16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF});
        send_pixel(24'h00ABCD, 10'd0, 10'd0);
        send_pixel(24'h00ABCD, 10'd1, 10'd0);
        send_pixel(24'hFFFFFF, 10'd1023, 10'd1023);
        i_start <= 1'b0;
        wait_drained();

        // Three quarter turns, merge that clamps, odd height, wrap on the left edge
        write_all(ROT_270, 10'd200, 64'(COLOUR_OFF), 64'(COLOUR_OFF), 64'(COLOUR_OFF),
                  64'(COLOUR_OFF), 64'hFFFFFF, {16'd3, 16'd0, 16'd0, 16'hFFFF});
        send_pixel(24'hFFFFFF, 10'd0, 10'd0);
        send_pixel(24'h000000, 10'd1023, 10'd1023);
        i_start <= 1'b0;
        wait_drained();

        // Random register settings, each followed by a run of random pixels
        for (int ph = 0; ph < 8; ph++) begin
            write_all(2'($urandom), brightness_setting(), colour_setting(), colour_setting(),
                      colour_setting(), colour_setting(), colour_setting(),
                      placement_setting());
            for (int n = 0; n < 125; n++) begin
                if ($urandom_range(0, 15) == 0) burst = !burst;
                src = 24'($urandom);
                if ($urandom_range(0, 7) == 0) src = key_now[COLOUR_W-1:0];
                send_pixel(src, 10'($urandom), 10'($urandom));
                // now and then let the pipeline empty completely before going on
                if ((ph == 0 && n == 60) || $urandom_range(0, 99) == 0) begin
                    i_start <= 1'b0;
                    wait_drained();
                end
            end
            i_start <= 1'b0;
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (8) @(posedge i_clk);
        if (error_total == 0 && writes_owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
